@@ design/mcwd_pkg.sv @@
package mcwd_pkg;

	// number of watchdog channels held in the block
	localparam int NUM_CHANNELS = 8;
	// bits of a channel index inside the block
	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	// channels that own a bit of the timeout mask
	localparam int MASK_W = 8;
	localparam int TIME_W = 48;
	localparam int LIMIT_W = 32;

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_REMOVE  = 3'd1,
		OP_PING    = 3'd2,
		OP_ENABLE  = 3'd3,
		OP_DISABLE = 3'd4,
		OP_CHECK   = 3'd5,
		OP_STATUS  = 3'd6,
		OP_OVERALL = 3'd7
	} func_t;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_WARN = 2'd1;
	localparam logic [1:0] STAT_CRIT = 2'd2;
	localparam logic [1:0] STAT_TMO  = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_TAIL,
		S_DONE
	} state_t;

endpackage

@@ design/multi_channel_watchdog.sv @@
// multi-channel watchdog with warning levels
//
// command channel: cmd_valid / cmd_stall with func, channel, timeout_value and
// now_ms. a request is taken at a rising edge where cmd_valid is high and
// cmd_stall is low. add, remove, ping, enable and disable change the addressed
// channel at that edge; check grades every enabled channel by its elapsed time.
// result channel: res_valid / res_stall with error, channel_status,
// overall_status and timeout_mask, exactly one result per request.
// every request walks all NUM_CHANNELS channels once through one shared
// subtract / compare unit (two stages): one channel per cycle, and the result
// is valid once the scan and a tail state are through.
// cmd_stall stays high from the request until its result is taken, so a new
// request is taken only once the result of the last one has been taken.
// while res_stall is high the result holds unchanged and no new request is
// taken. reset clears every channel to not in use, disabled and status ok;
// timeout and last-ping entries are written by add before they are ever used.
module multi_channel_watchdog (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  func,
	input  logic [2:0]  channel,
	input  logic [31:0] timeout_value,
	input  logic [47:0] now_ms,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic        error,
	output logic [1:0]  channel_status,
	output logic [1:0]  overall_status,
	output logic [7:0]  timeout_mask
);

	localparam int N = mcwd_pkg::NUM_CHANNELS;
	localparam int IW = mcwd_pkg::IDX_W;

	// channel state
	logic [N-1:0] in_use_q;
	logic [N-1:0] enabled_q;
	logic [1:0]   status_q    [N];
	logic [mcwd_pkg::LIMIT_W-1:0] timeout_q   [N];
	logic [mcwd_pkg::TIME_W-1:0]  last_ping_q [N];

	// sequencer
	mcwd_pkg::state_t state_q, state_d;
	logic [IW-1:0] cnt_q;
	logic          cnt_last;
	logic          cmd_take;
	logic          scan_en;

	// request held for the scan
	mcwd_pkg::func_t func_q;
	logic [IW-1:0]   chan_q;
	logic [mcwd_pkg::TIME_W-1:0] now_q;

	// decode of the incoming request
	mcwd_pkg::func_t op;
	logic [IW-1:0]   ch_idx;
	logic            ch_ok;
	logic            ch_used;

	// shared grading unit: stage 1 elapsed time, stage 2 compares
	logic                         vld_s1;
	logic [IW-1:0]                idx_s1;
	logic [mcwd_pkg::TIME_W-1:0]  elapsed_s1;
	logic [mcwd_pkg::LIMIT_W-1:0] limit_s1;

	logic       live_s2;
	logic       graded_s2;
	logic       tmo_s2;
	logic       crit_s2;
	logic       warn_s2;
	logic [34:0] e5_s2;
	logic [34:0] l4_s2;
	logic [33:0] e2_s2;
	logic [1:0] grade_s2;
	logic [1:0] stat_s2;

	// result registers
	logic       err_q;
	logic [1:0] chs_q;
	logic [1:0] worst_q;
	logic [7:0] mask_q;

	assign op      = mcwd_pkg::func_t'(func);
	assign ch_idx  = IW'(channel);
	assign ch_ok   = (32'(channel) < 32'(N));
	assign ch_used = ch_ok && in_use_q[ch_idx];

	assign cmd_take = cmd_valid && !cmd_stall;
	assign cnt_last = (cnt_q == IW'(N - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mcwd_pkg::S_IDLE: begin
				if (cmd_valid) begin
					state_d = mcwd_pkg::S_SCAN;
				end
			end
			mcwd_pkg::S_SCAN: begin
				if (cnt_last) begin
					state_d = mcwd_pkg::S_TAIL;
				end
			end
			mcwd_pkg::S_TAIL: begin
				state_d = mcwd_pkg::S_DONE;
			end
			mcwd_pkg::S_DONE: begin
				if (!res_stall) begin
					state_d = mcwd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mcwd_pkg::S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_stall = 1'b1;
		res_valid = 1'b0;
		scan_en   = 1'b0;
		unique case (state_q)
			mcwd_pkg::S_IDLE: cmd_stall = 1'b0;
			mcwd_pkg::S_SCAN: scan_en   = 1'b1;
			mcwd_pkg::S_TAIL: scan_en   = 1'b0;
			mcwd_pkg::S_DONE: res_valid = 1'b1;
			default:          cmd_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcwd_pkg::S_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= scan_en;
			if (cmd_take) begin
				cnt_q <= '0;
			end else if (scan_en && !cnt_last) begin
				cnt_q <= cnt_q + IW'(1);
			end
		end
	end

	// stage 2 grading: exact integer compares of elapsed against the limit
	// once elapsed is not above the limit it fits in the limit's 32 bits
	always_comb begin
		tmo_s2   = elapsed_s1 > mcwd_pkg::TIME_W'(limit_s1);
		e5_s2    = {3'b000, elapsed_s1[31:0]} + {1'b0, elapsed_s1[31:0], 2'b00};
		l4_s2    = {1'b0, limit_s1, 2'b00};
		e2_s2    = {1'b0, elapsed_s1[31:0], 1'b0};
		crit_s2  = e5_s2 > l4_s2;
		warn_s2  = e2_s2 > {2'b00, limit_s1};
		if (tmo_s2) begin
			grade_s2 = mcwd_pkg::STAT_TMO;
		end else if (crit_s2) begin
			grade_s2 = mcwd_pkg::STAT_CRIT;
		end else if (warn_s2) begin
			grade_s2 = mcwd_pkg::STAT_WARN;
		end else begin
			grade_s2 = mcwd_pkg::STAT_OK;
		end
		live_s2   = in_use_q[idx_s1] && enabled_q[idx_s1];
		graded_s2 = live_s2 && (func_q == mcwd_pkg::OP_CHECK);
		stat_s2   = graded_s2 ? grade_s2 : status_q[idx_s1];
	end

	// channel control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= '0;
			enabled_q <= '0;
			for (int i = 0; i < N; i++) begin
				status_q[i] <= mcwd_pkg::STAT_OK;
			end
		end else if (cmd_take) begin
			unique case (op)
				mcwd_pkg::OP_ADD: begin
					if (ch_ok) begin
						in_use_q[ch_idx]  <= 1'b1;
						enabled_q[ch_idx] <= 1'b1;
						status_q[ch_idx]  <= mcwd_pkg::STAT_OK;
					end
				end
				mcwd_pkg::OP_REMOVE: begin
					if (ch_used) begin
						in_use_q[ch_idx]  <= 1'b0;
						enabled_q[ch_idx] <= 1'b0;
						status_q[ch_idx]  <= mcwd_pkg::STAT_OK;
					end
				end
				mcwd_pkg::OP_PING: begin
					if (ch_used) begin
						status_q[ch_idx] <= mcwd_pkg::STAT_OK;
					end
				end
				mcwd_pkg::OP_ENABLE: begin
					if (ch_used) begin
						enabled_q[ch_idx] <= 1'b1;
						status_q[ch_idx]  <= mcwd_pkg::STAT_OK;
					end
				end
				mcwd_pkg::OP_DISABLE: begin
					if (ch_used) begin
						enabled_q[ch_idx] <= 1'b0;
					end
				end
				mcwd_pkg::OP_CHECK,
				mcwd_pkg::OP_STATUS,
				mcwd_pkg::OP_OVERALL: begin
				end
				default: begin
				end
			endcase
		end else if (vld_s1 && graded_s2) begin
			status_q[idx_s1] <= grade_s2;
		end
	end

	// timeout and last-ping tables, request capture, scan datapath
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			func_q <= op;
			chan_q <= ch_idx;
			now_q  <= now_ms;
			worst_q <= mcwd_pkg::STAT_OK;
			mask_q  <= '0;
			if (op == mcwd_pkg::OP_ADD) begin
				if (ch_ok) begin
					timeout_q[ch_idx]   <= timeout_value;
					last_ping_q[ch_idx] <= now_ms;
				end
			end
			if (op == mcwd_pkg::OP_PING || op == mcwd_pkg::OP_ENABLE) begin
				if (ch_used) begin
					last_ping_q[ch_idx] <= now_ms;
				end
			end
			if (op == mcwd_pkg::OP_ADD) begin
				err_q <= !ch_ok;
			end else if (op == mcwd_pkg::OP_REMOVE || op == mcwd_pkg::OP_PING ||
			             op == mcwd_pkg::OP_ENABLE || op == mcwd_pkg::OP_DISABLE ||
			             op == mcwd_pkg::OP_STATUS) begin
				err_q <= !ch_used;
			end else begin
				err_q <= 1'b0;
			end
			// query of a channel not in use reads as timed out
			if (op == mcwd_pkg::OP_STATUS && !ch_used) begin
				chs_q <= mcwd_pkg::STAT_TMO;
			end else begin
				chs_q <= mcwd_pkg::STAT_OK;
			end
		end
		// stage 1: elapsed time modulo the time width
		if (scan_en) begin
			elapsed_s1 <= now_q - last_ping_q[cnt_q];
			limit_s1   <= timeout_q[cnt_q];
			idx_s1     <= cnt_q;
		end
		// stage 2: fold the channel into the result
		if (vld_s1) begin
			if (live_s2 && (stat_s2 > worst_q)) begin
				worst_q <= stat_s2;
			end
			if (graded_s2 && tmo_s2 && (32'(idx_s1) < mcwd_pkg::MASK_W)) begin
				mask_q[3'(idx_s1)] <= 1'b1;
			end
			if (func_q == mcwd_pkg::OP_STATUS && idx_s1 == chan_q && in_use_q[idx_s1]) begin
				chs_q <= status_q[idx_s1];
			end
		end
	end

	assign error          = err_q;
	assign channel_status = chs_q;
	assign overall_status = worst_q;
	assign timeout_mask   = mask_q;

`ifndef SYNTHESIS
	a_take_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> state_q == mcwd_pkg::S_SCAN)
		else $error("request taken without starting a scan");

	a_mask_only_check: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && func_q != mcwd_pkg::OP_CHECK |-> timeout_mask == 8'd0)
		else $error("timeout mask set for a request other than check");

	a_status_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && func_q != mcwd_pkg::OP_STATUS |-> channel_status == mcwd_pkg::STAT_OK)
		else $error("channel status given for a request other than a query");

	a_mask_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (timeout_mask & ~8'(in_use_q)) == 8'd0)
		else $error("timeout reported for a channel not in use");
`endif

endmodule

@@ tb/sv/multi_channel_watchdog_tb.sv @@
module multi_channel_watchdog_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mcwd_pkg::*;

	// error flag values of a result
	localparam logic ERR_NONE   = 1'b0;
	localparam logic ERR_UNUSED = 1'b1;

	localparam int DIRECTED_ROWS   = 26;
	localparam int RANDOM_ITEMS    = 500;
	// receiver hold-off long enough to back the block up into its input
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int HOLD_OFF_AT     = 150;
	// sender waits for every outstanding result at this point
	localparam int DRAIN_PAUSE_AT  = 300;
	// stretch with no idling on either side
	localparam int STEADY_FROM     = 350;
	localparam int STEADY_TO       = 420;
	// one request walks all channels before its result comes
	localparam int DRAIN_CYCLES    = 4 * (NUM_CHANNELS + 3);
	localparam int STALL_LIMIT     = 1000;
	localparam int MAX_REPORTS     = 10;

	typedef struct packed {
		logic       error;
		logic [1:0] channel_status;
		logic [1:0] overall_status;
		logic [7:0] timeout_mask;
	} wd_result_t;

	// one row of the directed table, want is used only when typed is set
	typedef struct {
		func_t       op;
		logic [2:0]  ch;
		logic [31:0] tmo;
		logic [47:0] now;
		bit          typed;
		wd_result_t  want;
	} drill_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [2:0]  func = OP_OVERALL;
	logic [2:0]  channel = '0;
	logic [31:0] timeout_value = '0;
	logic [47:0] now_ms = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        error;
	logic [1:0]  channel_status;
	logic [1:0]  overall_status;
	logic [7:0]  timeout_mask;

	// own copy of the channel table
	bit          ch_in_use [NUM_CHANNELS] = '{default: 1'b0};
	bit          ch_enabled [NUM_CHANNELS] = '{default: 1'b0};
	logic [31:0] ch_timeout [NUM_CHANNELS] = '{default: '0};
	logic [47:0] ch_last_ping [NUM_CHANNELS] = '{default: '0};
	logic [1:0]  ch_status [NUM_CHANNELS] = '{default: STAT_OK};

	wd_result_t  awaited_results [$];
	int          mismatches = 0;
	int          results_taken = 0;
	int          quiet_cycles = 0;
	bit          steady_flow = 1'b0;
	bit          hold_off_request = 1'b0;
	logic [47:0] wall_ms = 48'hFFFF_FFFF_F000;

	drill_row_t directed [DIRECTED_ROWS] = '{
		// fresh after reset: nothing in use, every channel op reports not in use
		'{OP_OVERALL, 3'd0, 32'd0, 48'd0, 1'b1, {ERR_NONE, STAT_OK, STAT_OK, 8'h00}},
		'{OP_STATUS, 3'd0, 32'd0, 48'd0, 1'b1, {ERR_UNUSED, STAT_TMO, STAT_OK, 8'h00}},
		'{OP_REMOVE, 3'd7, 32'd0, 48'd0, 1'b1, {ERR_UNUSED, STAT_OK, STAT_OK, 8'h00}},
		'{OP_PING, 3'd3, 32'd0, 48'd5, 1'b1, {ERR_UNUSED, STAT_OK, STAT_OK, 8'h00}},
		'{OP_ENABLE, 3'd5, 32'd0, 48'd5, 1'b1, {ERR_UNUSED, STAT_OK, STAT_OK, 8'h00}},
		'{OP_DISABLE, 3'd2, 32'd0, 48'd5, 1'b1, {ERR_UNUSED, STAT_OK, STAT_OK, 8'h00}},
		'{OP_CHECK, 3'd0, 32'd0, 48'd5, 1'b1, {ERR_NONE, STAT_OK, STAT_OK, 8'h00}},
		// extremes of timeout and time
		'{OP_ADD, 3'd0, 32'hFFFF_FFFF, 48'd0, 1'b1, {ERR_NONE, STAT_OK, STAT_OK, 8'h00}},
		'{OP_ADD, 3'd7, 32'd0, 48'hFFFF_FFFF_FFFF, 1'b1,
			{ERR_NONE, STAT_OK, STAT_OK, 8'h00}},
		'{OP_ADD, 3'd3, 32'd10, 48'd100, 1'b1, {ERR_NONE, STAT_OK, STAT_OK, 8'h00}},
		// elapsed time wraps for channel 7, channel 3 sits exactly at half
		'{OP_CHECK, 3'd0, 32'd0, 48'd105, 1'b1, {ERR_NONE, STAT_OK, STAT_TMO, 8'h80}},
		'{OP_STATUS, 3'd7, 32'd0, 48'd105, 1'b1, {ERR_NONE, STAT_TMO, STAT_TMO, 8'h00}},
		// walk channel 3 through warning, 4/5 boundary, critical, timeout edge
		'{OP_CHECK, 3'd0, 32'd0, 48'd106, 1'b0, '0},
		'{OP_CHECK, 3'd0, 32'd0, 48'd108, 1'b0, '0},
		'{OP_CHECK, 3'd0, 32'd0, 48'd109, 1'b0, '0},
		'{OP_CHECK, 3'd0, 32'd0, 48'd110, 1'b0, '0},
		// disabled channel: ping still restarts it, check skips it
		'{OP_DISABLE, 3'd7, 32'd0, 48'd110, 1'b0, '0},
		'{OP_PING, 3'd7, 32'd0, 48'd110, 1'b0, '0},
		'{OP_CHECK, 3'd0, 32'd0, 48'd111, 1'b0, '0},
		'{OP_ENABLE, 3'd7, 32'd0, 48'd111, 1'b0, '0},
		// add over a channel in use, then remove and query the freed one
		'{OP_ADD, 3'd3, 32'd1000, 48'd200, 1'b0, '0},
		'{OP_REMOVE, 3'd0, 32'd0, 48'd200, 1'b0, '0},
		'{OP_STATUS, 3'd0, 32'd0, 48'd200, 1'b1, {ERR_UNUSED, STAT_TMO, STAT_OK, 8'h00}},
		// time going back wraps into a huge elapsed
		'{OP_CHECK, 3'd0, 32'd0, 48'd0, 1'b0, '0},
		'{OP_ADD, 3'd5, 32'h8000_0000, 48'h8000_0000_0000, 1'b0, '0},
		'{OP_OVERALL, 3'd0, 32'd0, 48'd0, 1'b0, '0}
	};

	multi_channel_watchdog dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.func           (func),
		.channel        (channel),
		.timeout_value  (timeout_value),
		.now_ms         (now_ms),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.error          (error),
		.channel_status (channel_status),
		.overall_status (overall_status),
		.timeout_mask   (timeout_mask)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// applies one request to the channel table and returns the result it gives
	function automatic wd_result_t apply_command(func_t op, logic [2:0] ch,
			logic [31:0] tmo, logic [47:0] now);
		wd_result_t  r;
		bit          known;
		logic [47:0] elapsed;
		bit [63:0]   el64;
		bit [63:0]   lim64;
		logic [1:0]  level;
		r = '0;
		known = (ch < NUM_CHANNELS) && ch_in_use[ch];
		case (op)
			OP_ADD: begin
				if (ch < NUM_CHANNELS) begin
					ch_in_use[ch] = 1'b1;
					ch_enabled[ch] = 1'b1;
					ch_timeout[ch] = tmo;
					ch_last_ping[ch] = now;
					ch_status[ch] = STAT_OK;
				end else begin
					r.error = ERR_UNUSED;
				end
			end
			OP_REMOVE: begin
				if (known) begin
					ch_in_use[ch] = 1'b0;
					ch_enabled[ch] = 1'b0;
					ch_status[ch] = STAT_OK;
				end else begin
					r.error = ERR_UNUSED;
				end
			end
			OP_PING, OP_ENABLE: begin
				if (known) begin
					if (op == OP_ENABLE)
						ch_enabled[ch] = 1'b1;
					ch_last_ping[ch] = now;
					ch_status[ch] = STAT_OK;
				end else begin
					r.error = ERR_UNUSED;
				end
			end
			OP_DISABLE: begin
				if (known)
					ch_enabled[ch] = 1'b0;
				else
					r.error = ERR_UNUSED;
			end
			OP_CHECK: begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (ch_in_use[i] && ch_enabled[i]) begin
						// subtraction at 48 bits gives the wrapped elapsed time
						elapsed = now - ch_last_ping[i];
						el64 = 64'(elapsed);
						lim64 = 64'(ch_timeout[i]);
						// 4/5 and 1/2 compared exactly by scaling both sides
						if (el64 > lim64)
							level = STAT_TMO;
						else if (el64 * 5 > lim64 * 4)
							level = STAT_CRIT;
						else if (el64 * 2 > lim64)
							level = STAT_WARN;
						else
							level = STAT_OK;
						ch_status[i] = level;
						if (level == STAT_TMO && i < MASK_W)
							r.timeout_mask[i] = 1'b1;
					end
				end
			end
			OP_STATUS: begin
				if (known) begin
					r.channel_status = ch_status[ch];
				end else begin
					r.error = ERR_UNUSED;
					r.channel_status = STAT_TMO;
				end
			end
			default: ;
		endcase
		// worst stored status over enabled channels in use, after the update
		r.overall_status = STAT_OK;
		for (int i = 0; i < NUM_CHANNELS; i++)
			if (ch_in_use[i] && ch_enabled[i] && ch_status[i] > r.overall_status)
				r.overall_status = ch_status[i];
		return r;
	endfunction

	// drives one request after a random gap, holds it until taken, then
	// records what it must produce
	task automatic offer_request(func_t op, logic [2:0] ch, logic [31:0] tmo,
			logic [47:0] now, bit typed, wd_result_t typed_want);
		int         gap;
		wd_result_t predicted;
		gap = steady_flow ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		func <= op;
		channel <= ch;
		timeout_value <= tmo;
		now_ms <= now;
		do @(posedge clk); while (!(cmd_valid && !cmd_stall));
		predicted = apply_command(op, ch, tmo, now);
		awaited_results.push_back(typed ? typed_want : predicted);
	endtask

	task automatic note_mismatch(string field, logic [7:0] want, logic [7:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch on result %0d, %s: expected %0h, got %0h",
				results_taken, field, want, got);
	endtask

	// result side: random stall per result, one long hold-off on request
	initial begin : result_side
		int         stall_len;
		wd_result_t want;
		forever begin
			if (hold_off_request) begin
				stall_len = HOLD_OFF_CYCLES;
				hold_off_request = 1'b0;
			end else begin
				stall_len = steady_flow ? 0 : $urandom_range(0, 7);
			end
			if (stall_len > 0) begin
				@(negedge clk);
				res_stall <= 1'b1;
				repeat (stall_len) @(negedge clk);
				res_stall <= 1'b0;
			end
			do @(posedge clk); while (!(res_valid && !res_stall));
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d arrived with no request outstanding", results_taken);
			end else begin
				want = awaited_results.pop_front();
				if (error !== want.error)
					note_mismatch("error", 8'(want.error), 8'(error));
				if (channel_status !== want.channel_status)
					note_mismatch("channel_status", 8'(want.channel_status),
						8'(channel_status));
				if (overall_status !== want.overall_status)
					note_mismatch("overall_status", 8'(want.overall_status),
						8'(overall_status));
				if (timeout_mask !== want.timeout_mask)
					note_mismatch("timeout_mask", want.timeout_mask, timeout_mask);
			end
			results_taken++;
		end
	end

	// ends the run when neither side moves for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no request or result moved for %0d cycles", quiet_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin : request_side
		func_t       op;
		logic [2:0]  ch;
		logic [31:0] tmo;
		int          roll;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int k = 0; k < DIRECTED_ROWS; k++)
			offer_request(directed[k].op, directed[k].ch, directed[k].tmo, directed[k].now,
				directed[k].typed, directed[k].want);

		// random part: mostly requests on channels in use, time moving forward
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == HOLD_OFF_AT)
				hold_off_request = 1'b1;
			if (n == DRAIN_PAUSE_AT) begin
				// sender goes quiet until every result is back
				@(negedge clk);
				cmd_valid <= 1'b0;
				while (awaited_results.size() != 0) @(posedge clk);
			end
			steady_flow = (n >= STEADY_FROM && n < STEADY_TO);

			roll = $urandom_range(0, 99);
			if (roll < 14)
				op = OP_ADD;
			else if (roll < 19)
				op = OP_REMOVE;
			else if (roll < 34)
				op = OP_PING;
			else if (roll < 42)
				op = OP_ENABLE;
			else if (roll < 50)
				op = OP_DISABLE;
			else if (roll < 75)
				op = OP_CHECK;
			else if (roll < 89)
				op = OP_STATUS;
			else
				op = OP_OVERALL;

			// lean toward channels that are in use
			ch = 3'($urandom_range(0, 7));
			if ($urandom_range(0, 3) != 0)
				for (int t = 0; t < 16 && !ch_in_use[ch]; t++)
					ch = 3'($urandom_range(0, 7));

			// short timeouts so checks land on every level, a few extremes
			roll = $urandom_range(0, 99);
			if (roll < 85)
				tmo = 32'($urandom_range(1, 200));
			else if (roll < 90)
				tmo = 32'd0;
			else if (roll < 95)
				tmo = 32'hFFFF_FFFF;
			else
				tmo = $urandom;

			// time crawls forward and wraps, now and then jumps anywhere
			roll = $urandom_range(0, 99);
			if (roll < 3)
				wall_ms = {16'($urandom), 32'($urandom)};
			else if (roll < 13)
				wall_ms = wall_ms + 48'($urandom_range(0, 1000));
			else
				wall_ms = wall_ms + 48'($urandom_range(0, 40));

			offer_request(op, ch, tmo, wall_ms, 1'b0, '0);
		end

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
